// File: src/sha256_hash_engine_core_defines.svh
// Assertion macros for the SHA-256 hash engine core.
// Used by the top level only; needs a clock i_clk and reset i_rst_n in scope.
`ifndef SHA256_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA256_HASH_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SHA_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SHA_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sha256_pkg.sv
// Shared types, constants and hash functions for the SHA-256 engine.
// No dependencies; used by sha256_hash_engine_core, sha256_sched and sha256_round.
`default_nettype none

package sha256_pkg;

    // Eight 32-bit words: hash state or round variables, index 0 = a / H0
    typedef logic [7:0][31:0] t_words8;

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic        shift;       // advance the schedule by one round
        logic        put;         // write message bytes
        logic        put_merge;   // keep the bytes already in the word
        logic [3:0]  put_idx;
        logic [31:0] put_data;
        logic        pad;         // clear words from keep_words upward
        logic [4:0]  keep_words;
        logic        put_len;     // write bit length into words 14 and 15
        logic [63:0] bit_len;
    } t_sched_ctl;

    localparam t_words8 HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] PAD_BYTE_WORD = 32'h8000_0000;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

// File: src/sha256_stream_if.sv
// Valid/ready channel interfaces for message words in and digest words out.
// No dependencies.
`default_nettype none

interface sha256_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;

    modport source(output valid, data_word, valid_bytes, end_of_message, input ready);
    modport sink(input valid, data_word, valid_bytes, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    modport source(output valid, digest_word, word_index, final_word, input ready);
    modport sink(input valid, digest_word, word_index, final_word, output ready);
endinterface

`default_nettype wire

// File: src/sha256_hash_engine_core.sv
// SHA-256 engine: takes a message as big-endian 32-bit words and returns the
// eight digest words H0..H7 once the word marked end of message is in. An
// input request is taken in S_IDLE, then its bytes go into the block buffer
// in S_LOAD, one schedule word at a time when they straddle two. The cycle that
// writes the last byte of a 64-byte block also loads the round variables; the
// block then runs 64 rounds on the single round unit at one round per cycle
// (S_COMP) and is folded into the hash (S_FOLD). The end of a message adds an
// S_LOAD step to place the 0x80 byte, an S_PAD step before each closing
// compression unless the 0x80 byte ends that block, and one or two block
// compressions, then the digest leaves one word per accepted output request.
// The engine takes no new input request from acceptance of a word until it is
// done.
// Depends on sha256_pkg, sha256_stream_if, sha256_sched, sha256_round and sha256_hash_engine_core_defines.svh.
`default_nettype none

`include "sha256_hash_engine_core_defines.svh"

module sha256_hash_engine_core (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    sha256_in_if.sink     i_msg,
    sha256_out_if.source  o_dig
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_PAD  = 6'b000100,
        S_COMP = 6'b001000,
        S_FOLD = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [5:0]          r_fill, n_fill;
    logic [60:0]         r_total, n_total;
    logic [31:0]         r_pend, n_pend;
    logic [2:0]          r_cnt, n_cnt;
    logic                r_last, n_last;
    logic                r_padb, n_padb;     // 0x80 byte already queued
    logic                r_final, n_final;   // length block is in compression
    logic [5:0]          r_round, n_round;
    logic [2:0]          r_emit_idx, n_emit_idx;
    sha256_pkg::t_words8 r_hash, n_hash;
    sha256_pkg::t_words8 r_work, n_work;

    sha256_pkg::t_sched_ctl sched_ctl;
    sha256_pkg::t_words8    round_out;
    logic [31:0]            sched_w;

    logic [2:0]  in_cnt;
    logic [1:0]  off;
    logic [2:0]  room;
    logic [2:0]  take;
    logic [31:0] take_mask;
    logic [5:0]  fill_nx;
    logic [2:0]  cnt_nx;
    logic [6:0]  fill_up;
    logic        in_acc;
    logic        out_acc;

    sha256_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (sched_w)
    );

    sha256_round u_round (
        .i_vars (r_work),
        .i_w    (sched_w),
        .i_k    (sha256_pkg::K_TABLE[r_round]),
        .o_vars (round_out)
    );

    // Handshakes and output payload
    assign i_msg.ready       = (r_state == S_IDLE);
    assign o_dig.valid       = (r_state == S_EMIT);
    assign o_dig.digest_word = r_hash[0];
    assign o_dig.word_index  = r_emit_idx;
    assign o_dig.final_word  = (r_emit_idx == 3'd7);
    assign in_acc            = i_msg.valid && i_msg.ready;
    assign out_acc           = o_dig.valid && o_dig.ready;

    // Byte counts above four count as four
    assign in_cnt = i_msg.valid_bytes[2] ? 3'd4 : i_msg.valid_bytes;

    // Bytes that fit into the current schedule word
    assign off     = r_fill[1:0];
    assign room    = 3'd4 - {1'b0, off};
    assign take    = (r_cnt < room) ? r_cnt : room;
    assign fill_nx = r_fill + {3'b000, take};
    assign cnt_nx  = r_cnt - take;
    assign fill_up = {1'b0, r_fill} + 7'd3;

    always_comb begin
        case (take)
            3'd0:    take_mask = 32'h0000_0000;
            3'd1:    take_mask = 32'hff00_0000;
            3'd2:    take_mask = 32'hffff_0000;
            3'd3:    take_mask = 32'hffff_ff00;
            default: take_mask = 32'hffff_ffff;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_total    = r_total;
        n_pend     = r_pend;
        n_cnt      = r_cnt;
        n_last     = r_last;
        n_padb     = r_padb;
        n_final    = r_final;
        n_round    = r_round;
        n_emit_idx = r_emit_idx;
        n_hash     = r_hash;
        n_work     = r_work;
        sched_ctl  = '0;
        sched_ctl.bit_len = {r_total, 3'b000};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_total = r_total + {58'd0, in_cnt};
                    n_last  = i_msg.end_of_message;
                    n_padb  = 1'b0;
                    if (in_cnt != 3'd0) begin
                        n_pend  = i_msg.data_word;
                        n_cnt   = in_cnt;
                        n_state = S_LOAD;
                    end else if (i_msg.end_of_message) begin
                        n_pend  = sha256_pkg::PAD_BYTE_WORD;
                        n_cnt   = 3'd1;
                        n_padb  = 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                sched_ctl.put       = 1'b1;
                sched_ctl.put_merge = (off != 2'd0);
                sched_ctl.put_idx   = r_fill[5:2];
                sched_ctl.put_data  = (r_pend & take_mask) >> {off, 3'b000};
                n_fill = fill_nx;
                n_cnt  = cnt_nx;
                n_pend = r_pend << {take, 3'b000};
                if (fill_nx == 6'd0) begin
                    n_work  = r_hash;
                    n_round = 6'd0;
                    n_state = S_COMP;
                end else if (cnt_nx == 3'd0) begin
                    if (!r_last) begin
                        n_state = S_IDLE;
                    end else if (!r_padb) begin
                        n_pend = sha256_pkg::PAD_BYTE_WORD;
                        n_cnt  = 3'd1;
                        n_padb = 1'b1;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // Zero fill; length only if it fits in this block
                sched_ctl.pad        = 1'b1;
                sched_ctl.keep_words = fill_up[6:2];
                sched_ctl.put_len    = (r_fill <= 6'd56);
                n_final = (r_fill <= 6'd56);
                n_fill  = 6'd0;
                n_work  = r_hash;
                n_round = 6'd0;
                n_state = S_COMP;
            end
            S_COMP: begin
                sched_ctl.shift = 1'b1;
                n_work  = round_out;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int j = 0; j < 8; j++) begin
                    n_hash[j] = r_hash[j] + r_work[j];
                end
                if (r_final) begin
                    n_emit_idx = 3'd0;
                    n_state    = S_EMIT;
                end else if (r_cnt != 3'd0) begin
                    n_state = S_LOAD;
                end else if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_padb) begin
                    n_pend  = sha256_pkg::PAD_BYTE_WORD;
                    n_cnt   = 3'd1;
                    n_padb  = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    n_hash     = sha256_pkg::t_words8'(r_hash >> 32);
                    n_emit_idx = r_emit_idx + 3'd1;
                    if (r_emit_idx == 3'd7) begin
                        n_hash  = sha256_pkg::HASH_INIT;
                        n_total = 61'd0;
                        n_fill  = 6'd0;
                        n_final = 1'b0;
                        n_last  = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= 6'd0;
            r_total    <= 61'd0;
            r_cnt      <= 3'd0;
            r_last     <= 1'b0;
            r_padb     <= 1'b0;
            r_final    <= 1'b0;
            r_round    <= 6'd0;
            r_emit_idx <= 3'd0;
            r_hash     <= sha256_pkg::HASH_INIT;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_total    <= n_total;
            r_cnt      <= n_cnt;
            r_last     <= n_last;
            r_padb     <= n_padb;
            r_final    <= n_final;
            r_round    <= n_round;
            r_emit_idx <= n_emit_idx;
            r_hash     <= n_hash;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_work <= n_work;
    end

    // Checks
    `SHA_CHK_NOW(a_no_out_while_ready, i_msg.ready, !o_dig.valid, "digest valid while taking input")
    `SHA_CHK_NEXT(a_round_step, (r_state == S_COMP) && (r_round != 6'd63), (r_state == S_COMP) && (r_round == $past(r_round) + 6'd1), "round counter skipped")
    `SHA_CHK_NEXT(a_digest_done, out_acc && o_dig.final_word, (r_state == S_IDLE) && (r_fill == 6'd0) && (r_total == 61'd0), "engine not reinitialized after digest")
    `SHA_CHK_NEXT(a_final_emits, (r_state == S_FOLD) && r_final, o_dig.valid && (o_dig.word_index == 3'd0), "digest not presented after last block")

endmodule

`default_nettype wire

// File: src/sha256_sched.sv
// Message block buffer and rolling 16-word message schedule.
// Depends on sha256_pkg (control struct, sigma functions).
`default_nettype none

module sha256_sched (
    input  wire logic                   i_clk,
    input  wire sha256_pkg::t_sched_ctl i_ctl,
    output logic [31:0]                 o_w
);

    logic [31:0] r_win [16];
    logic [31:0] w_next;

    // W[t+16] from the current window, window[0] holds W[t]
    assign w_next = sha256_pkg::small_sigma1(r_win[14]) + r_win[9]
                  + sha256_pkg::small_sigma0(r_win[1]) + r_win[0];

    assign o_w = r_win[0];

    // Shift during rounds, byte writes during fill, clear and length at pad
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= w_next;
        end else if (i_ctl.put) begin
            r_win[i_ctl.put_idx] <= (i_ctl.put_merge ? r_win[i_ctl.put_idx] : 32'h0)
                                  | i_ctl.put_data;
        end else if (i_ctl.pad) begin
            // Words 14 and 15 take the length instead of zero when it fits
            for (int i = 0; i < 16; i++) begin
                if (5'(i) >= i_ctl.keep_words && !(i_ctl.put_len && i >= 14)) begin
                    r_win[i] <= 32'h0;
                end
            end
            if (i_ctl.put_len) begin
                r_win[14] <= i_ctl.bit_len[63:32];
                r_win[15] <= i_ctl.bit_len[31:0];
            end
        end
    end

endmodule

`default_nettype wire

// File: src/sha256_round.sv
// One SHA-256 compression round, shared over all 64 rounds of a block.
// Depends on sha256_pkg (word types, sigma functions).
`default_nettype none

module sha256_round (
    input  wire sha256_pkg::t_words8 i_vars,
    input  wire logic [31:0]         i_w,
    input  wire logic [31:0]         i_k,
    output sha256_pkg::t_words8      o_vars
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign ch  = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
    assign maj = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
    assign t1  = i_vars[7] + sha256_pkg::big_sigma1(i_vars[4]) + ch + i_k + i_w;
    assign t2  = sha256_pkg::big_sigma0(i_vars[0]) + maj;

    // Rotate a..h down one place, inject the new a and e
    always_comb begin
        o_vars    = sha256_pkg::t_words8'(i_vars << 32);
        o_vars[0] = t1 + t2;
        o_vars[4] = i_vars[3] + t1;
    end

endmodule

`default_nettype wire

// File: sim/sha256_hash_engine_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sha256_hash_engine_core: message words in, digest words out.
// Needs sha256_stream_if (sha256_in_if, sha256_out_if) and the engine RTL.
// A local SHA-256 model predicts each digest not typed in; each digest is checked against the DUT output.

module sha256_hash_engine_core_tb;

    localparam int RESET_CYCLES     = 7;
    localparam int ITEM_TARGET      = 350;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 2500;
    localparam int DRAIN_CYCLES     = 200;
    localparam int MAX_REPORTS      = 10;
    localparam int N_DIRECTED       = 16;
    localparam int N_EDGE_LENGTHS   = 24;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum {RX_STREAM, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        last;
    } t_digest_exp;

    typedef struct packed {
        logic [31:0]  data;
        logic [2:0]   nbytes;
        logic         eom;
        logic         has_known;
        logic [255:0] known;    // H0 in the top bits
    } t_stim_row;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Directed requests; known digests typed in, the rest come from the model
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{32'h0000_0000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},   // empty message
        '{32'h6162_63ff, 3'd3, 1'b1, 1'b1, ABC_DIGEST},     // "abc", byte past count ignored
        '{32'h6100_0000, 3'd1, 1'b0, 1'b0, 256'h0},         // "abc" as partial words
        '{32'h6263_5a5a, 3'd2, 1'b1, 1'b1, ABC_DIGEST},
        '{32'hdead_beef, 3'd0, 1'b0, 1'b0, 256'h0},         // empty non-final word
        '{32'hffff_ffff, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{32'hffff_ffff, 3'd4, 1'b1, 1'b0, 256'h0},
        '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 256'h0},
        '{32'h8000_0001, 3'd7, 1'b1, 1'b0, 256'h0},         // count above four
        '{32'h1234_5678, 3'd5, 1'b0, 1'b0, 256'h0},
        '{32'h9abc_def0, 3'd6, 1'b0, 1'b0, 256'h0},
        '{32'h0f0f_0f0f, 3'd3, 1'b0, 1'b0, 256'h0},         // unaligned stream from here
        '{32'ha5a5_a5a5, 3'd1, 1'b0, 1'b0, 256'h0},
        '{32'h5a5a_5a5a, 3'd2, 1'b1, 1'b0, 256'h0},
        '{32'h7fff_ffff, 3'd4, 1'b0, 1'b0, 256'h0},
        '{32'h0000_0001, 3'd6, 1'b1, 1'b0, 256'h0}
    };

    // Message lengths around the pad and extra-block boundaries
    localparam int EDGE_LENGTHS [N_EDGE_LENGTHS] = '{
        0, 1, 2, 3, 4, 5, 52, 53, 54, 55, 56, 57,
        59, 60, 61, 63, 64, 65, 117, 119, 120, 121, 127, 128
    };

    logic i_clk;
    logic i_rst_n;

    sha256_in_if  msg_if ();
    sha256_out_if dig_if ();

    sha256_hash_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_dig   (dig_if)
    );

    // Hash model state
    logic [31:0] pred_h [8];
    logic [31:0] pred_w [16];
    logic [60:0] pred_bytes;
    logic [5:0]  pred_fill;

    t_digest_exp digest_q [$];

    int  mismatches    = 0;
    int  rx_count      = 0;
    int  req_count     = 0;
    int  msg_done      = 0;
    int  long_holds    = 0;
    int  burst_left    = 1;
    int  longest_msg   = 0;
    bit  long_hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    task automatic hash_restart();
        pred_h     = H_START;
        pred_bytes = '0;
        pred_fill  = '0;
    endtask

    // 64 rounds over the 16-word window, folded into the hash state
    task automatic compress_blk();
        logic [31:0] v [8];
        logic [31:0] w, w2, w15, t1, t2;
        v = pred_h;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w = pred_w[r];
            end else begin
                w2  = pred_w[(r - 2) % 16];
                w15 = pred_w[(r - 15) % 16];
                w = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + pred_w[(r - 7) % 16]
                    + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + pred_w[r % 16];
                pred_w[r % 16] = w;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) pred_h[j] = pred_h[j] + v[j];
    endtask

    task automatic put_byte(input logic [7:0] b);
        int idx;
        int sh;
        idx = int'(pred_fill[5:2]);
        sh  = 24 - 8 * int'(pred_fill[1:0]);
        if (pred_fill[1:0] == 2'd0) pred_w[idx] = '0;
        pred_w[idx] = pred_w[idx] | (32'(b) << sh);
        pred_fill = pred_fill + 6'd1;
        if (pred_fill == 6'd0) compress_blk();
    endtask

    // Model one message word; on end of message return the digest
    task automatic hash_word(input logic [31:0] d, input logic [2:0] n, input logic eom,
                             output logic done, output logic [7:0][31:0] dig);
        int cnt;
        logic [63:0] bit_len;
        done = 1'b0;
        dig  = '0;
        cnt  = (n > 3'd4) ? 4 : int'(n);
        for (int i = 0; i < cnt; i++) put_byte(d[31 - 8 * i -: 8]);
        pred_bytes = pred_bytes + 61'(cnt);
        if (eom) begin
            bit_len = {pred_bytes, 3'b000};
            put_byte(PAD_MARK);
            if (pred_fill > 6'd56) begin
                while (pred_fill != 6'd0) put_byte(8'h00);
            end
            for (int i = (int'(pred_fill) + 3) / 4; i < 14; i++) pred_w[i] = '0;
            pred_w[14] = bit_len[63:32];
            pred_w[15] = bit_len[31:0];
            compress_blk();
            for (int i = 0; i < 8; i++) dig[i] = pred_h[i];
            hash_restart();
            done = 1'b1;
        end
    endtask

    // Offer one request, wait for it to be taken, then maybe leave a gap
    task automatic send_req(input logic [31:0] d, input logic [2:0] n, input logic eom,
                            input logic has_known, input logic [255:0] known);
        logic done;
        logic [7:0][31:0] dig;
        int gap;
        msg_if.valid          <= 1'b1;
        msg_if.data_word      <= d;
        msg_if.valid_bytes    <= n;
        msg_if.end_of_message <= eom;
        do @(posedge i_clk); while (!msg_if.ready);
        hash_word(d, n, eom, done, dig);
        req_count++;
        if (done) begin
            msg_done++;
            for (int i = 0; i < 8; i++) begin
                digest_q.push_back(t_digest_exp'{
                    word: has_known ? known[255 - 32 * i -: 32] : dig[i],
                    pos:  3'(i),
                    last: (i == 7)});
            end
        end
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
        end
    endtask

    // Sender goes quiet until every predicted digest word is out
    task automatic wait_drained();
        msg_if.valid <= 1'b0;
        do @(posedge i_clk); while (digest_q.size() != 0);
    endtask

    // One message of nbytes; noisy ones mix in partial, empty and over-count words
    task automatic send_message(input int nbytes, input bit noisy);
        int left;
        int k;
        logic [2:0] nb;
        left = nbytes;
        if (nbytes > longest_msg) longest_msg = nbytes;
        forever begin
            if (noisy && $urandom_range(0, 5) == 0) begin
                k = $urandom_range(0, 2);
                if (k == 0 || left == 0) begin
                    send_req($urandom, 3'd0, 1'b0, 1'b0, 256'h0);
                end else if (k == 1 || left < 4) begin
                    k = $urandom_range(1, (left < 3) ? left : 3);
                    send_req($urandom, 3'(k), 1'b0, 1'b0, 256'h0);
                    left -= k;
                end else begin
                    send_req($urandom, 3'($urandom_range(5, 7)), 1'b0, 1'b0, 256'h0);
                    left -= 4;
                end
            end else if (left > 4) begin
                send_req($urandom, 3'd4, 1'b0, 1'b0, 256'h0);
                left -= 4;
            end else if (left == 4 && $urandom_range(0, 3) == 0) begin
                // full last word, then an empty closing word
                send_req($urandom, 3'd4, 1'b0, 1'b0, 256'h0);
                send_req($urandom, 3'd0, 1'b1, 1'b0, 256'h0);
                break;
            end else begin
                nb = 3'(left);
                if (left == 4 && $urandom_range(0, 2) == 0) nb = 3'($urandom_range(5, 7));
                send_req($urandom, nb, 1'b1, 1'b0, 256'h0);
                break;
            end
        end
    endtask

    // Output side: stall patterns, plus one long hold on request
    initial begin : ready_pattern
        t_rx_mode mode;
        int phase_left;
        int tick;
        dig_if.ready <= 1'b0;
        mode = RX_STREAM;
        phase_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                dig_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
                long_holds++;
            end else begin
                if (phase_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 2));
                    phase_left = $urandom_range(20, 80);
                end
                phase_left--;
                tick++;
                case (mode)
                    RX_STREAM:   dig_if.ready <= 1'b1;
                    RX_RANDOM:   dig_if.ready <= ($urandom_range(0, 9) < 6);
                    RX_PERIODIC: dig_if.ready <= ((tick % 5) >= 3);
                    default:     dig_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // Compare each digest word with the oldest prediction
    always @(posedge i_clk) begin : digest_check
        t_digest_exp want;
        if (i_rst_n && dig_if.valid && dig_if.ready) begin
            rx_count++;
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected digest word %h pos %0d last %b", $realtime,
                             dig_if.digest_word, dig_if.word_index, dig_if.final_word);
            end else begin
                want = digest_q.pop_front();
                if (dig_if.digest_word !== want.word || dig_if.word_index !== want.pos ||
                    dig_if.final_word !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                 $realtime, want.word, want.pos, want.last,
                                 dig_if.digest_word, dig_if.word_index, dig_if.final_word);
                end
            end
        end
    end

    // Watchdog: too long without any accepted request on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int msg_idx;
        int len;
        i_rst_n               <= 1'b0;
        msg_if.valid          <= 1'b0;
        msg_if.data_word      <= '0;
        msg_if.valid_bytes    <= '0;
        msg_if.end_of_message <= 1'b0;
        hash_restart();
        for (int i = 0; i < 16; i++) pred_w[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int row = 0; row < N_DIRECTED; row++) begin
            send_req(DIRECTED[row].data, DIRECTED[row].nbytes, DIRECTED[row].eom,
                     DIRECTED[row].has_known, DIRECTED[row].known);
        end
        wait_drained();

        // Random messages: mostly well formed, some noisy
        msg_idx = 0;
        while (req_count < ITEM_TARGET) begin
            if (msg_idx == 3) long_hold_req = 1'b1;
            if (msg_idx == 12) wait_drained();
            if ($urandom_range(0, 9) < 4)
                len = EDGE_LENGTHS[$urandom_range(0, N_EDGE_LENGTHS - 1)];
            else
                len = $urandom_range(0, 100);
            send_message(len, $urandom_range(0, 3) == 0);
            msg_idx++;
        end

        // Let the last digests out, then watch for stray output
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests in %0d messages (longest %0d bytes), %0d long output hold(s).",
                 req_count, msg_done, longest_msg, long_holds);
        $display("Checked %0d digest words, %0d mismatch(es).", rx_count, mismatches);
        if (mismatches == 0 && digest_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
